[rtl/core/nsf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsf_pkg
// Shared types, constants and a helper function of the NMEA sentence framer.
// ----------------------------------------------------------------------------
package nsf_pkg;

  localparam logic [7:0]  MAX_LEN      = 8'd128;
  localparam int          HDR_W        = 48;
  localparam int          CFG_IDX_W    = 1;
  localparam logic [2:0]  XOR_START    = 3'd5;
  localparam logic [2:0]  HDR_BYTES    = 3'd6;
  localparam logic [6:0]  COMMA_MAX    = 7'd127;
  localparam logic [7:0]  COUNT_MAX    = 8'd255;

  localparam logic [HDR_W-1:0] FIRST_HEADER_RST  = 48'd39888708126529;
  localparam logic [HDR_W-1:0] SECOND_HEADER_RST = 48'd39888708848963;

  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_HEADER  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_HEADER = 1'd1;

  localparam logic [7:0] CH_DOLLAR  = 8'h24;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] HEX_TEN    = 8'h0A;

  typedef enum logic [1:0] {
    KIND_OTHER  = 2'd0,
    KIND_FIRST  = 2'd1,
    KIND_SECOND = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic       checksum_ok;
    logic [7:0] computed_sum;
    logic [7:0] received_sum;
    logic [7:0] sentence_length;
    logic [7:0] field_total;
    logic       too_long;
  } result_t;

  function automatic logic [7:0] hex_value(input logic [7:0] c);
    logic [7:0] v;
    begin
      v = 8'd0;
      if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
        v = c - CH_UPPER_A + HEX_TEN;
      end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
        v = c - CH_LOWER_A + HEX_TEN;
      end else if (c >= CH_ZERO && c <= CH_NINE) begin
        v = c - CH_ZERO;
      end
      return v;
    end
  endfunction

endpackage

[rtl/core/nsf_in_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsf_in_stage
// Input register: holds one received byte until the framer takes it.
// ----------------------------------------------------------------------------
module nsf_in_stage (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       out_free,
  output logic       step,
  output logic [7:0] byte_q
);

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] byte_r;

  assign step      = valid_r && out_free;
  assign in_tready = !valid_r || out_free;
  assign byte_q    = byte_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_tvalid && in_tready) begin
      valid_nxt = 1'b1;
    end else if (step) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      byte_r <= in_tdata;
    end
  end

endmodule

[rtl/core/nsf_framer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsf_framer
// Sentence state: framing, running checksum, header capture, comma count.
// ----------------------------------------------------------------------------
module nsf_framer (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     step,
  input  logic [7:0]               byte_q,
  input  logic [nsf_pkg::HDR_W-1:0] first_header,
  input  logic [nsf_pkg::HDR_W-1:0] second_header,
  output logic                     res_valid,
  output nsf_pkg::result_t         res
);

  logic                      in_sentence_r, in_sentence_nxt;
  logic [7:0]                byte_count_r, byte_count_nxt;
  logic [7:0]                running_xor_r, running_xor_nxt;
  logic [7:0]                delay_r [4];
  logic [7:0]                delay_nxt [4];
  logic [nsf_pkg::HDR_W-1:0] header_r, header_nxt;
  logic [6:0]                comma_r, comma_nxt;
  logic [7:0]                prev_r;

  logic                      is_dollar;
  logic                      is_lf;
  logic                      close;
  logic [7:0]                total;
  logic                      over;
  logic [nsf_pkg::HDR_W-1:0] hdr_cmp;
  logic [7:0]                hex_hi;
  logic [7:0]                hex_lo;
  logic [7:0]                rx_sum;

  assign is_dollar = (byte_q == nsf_pkg::CH_DOLLAR);
  assign is_lf     = (byte_q == nsf_pkg::CH_LF);
  assign close     = is_lf && in_sentence_r && (prev_r == nsf_pkg::CH_CR);
  assign res_valid = step && close;

  always_comb begin
    total   = (byte_count_r < nsf_pkg::COUNT_MAX) ? byte_count_r + 8'd1 : nsf_pkg::COUNT_MAX;
    over    = (total > nsf_pkg::MAX_LEN);
    hdr_cmp = (byte_count_r < {5'd0, nsf_pkg::HDR_BYTES}) ?
              {header_r[nsf_pkg::HDR_W-9:0], byte_q} : header_r;
    hex_hi  = nsf_pkg::hex_value(delay_r[1]);
    hex_lo  = nsf_pkg::hex_value(delay_r[2]);
    rx_sum  = {hex_hi[3:0], 4'd0} + hex_lo;

    res.kind = nsf_pkg::KIND_OTHER;
    if (total >= {5'd0, nsf_pkg::HDR_BYTES}) begin
      if (hdr_cmp == first_header) begin
        res.kind = nsf_pkg::KIND_FIRST;
      end else if (hdr_cmp == second_header) begin
        res.kind = nsf_pkg::KIND_SECOND;
      end
    end
    res.checksum_ok     = (running_xor_r == rx_sum) && !over;
    res.computed_sum    = running_xor_r;
    res.received_sum    = rx_sum;
    res.sentence_length = over ? nsf_pkg::MAX_LEN : total;
    res.field_total     = {1'b0, comma_r} + 8'd1;
    res.too_long        = over;
  end

  always_comb begin
    in_sentence_nxt = in_sentence_r;
    byte_count_nxt  = byte_count_r;
    running_xor_nxt = running_xor_r;
    delay_nxt       = delay_r;
    header_nxt      = header_r;
    comma_nxt       = comma_r;
    if (is_dollar) begin
      in_sentence_nxt = 1'b1;
      byte_count_nxt  = 8'd1;
      running_xor_nxt = 8'd0;
      delay_nxt[0]    = 8'd0;
      delay_nxt[1]    = 8'd0;
      delay_nxt[2]    = 8'd0;
      delay_nxt[3]    = nsf_pkg::CH_DOLLAR;
      header_nxt      = {{(nsf_pkg::HDR_W-8){1'b0}}, nsf_pkg::CH_DOLLAR};
      comma_nxt       = 7'd0;
    end else if (is_lf) begin
      if (close) begin
        in_sentence_nxt = 1'b0;
      end
    end else if (in_sentence_r) begin
      if (byte_count_r >= {5'd0, nsf_pkg::XOR_START}) begin
        running_xor_nxt = running_xor_r ^ delay_r[0];
      end
      delay_nxt[0] = delay_r[1];
      delay_nxt[1] = delay_r[2];
      delay_nxt[2] = delay_r[3];
      delay_nxt[3] = byte_q;
      if (byte_count_r < {5'd0, nsf_pkg::HDR_BYTES}) begin
        header_nxt = {header_r[nsf_pkg::HDR_W-9:0], byte_q};
      end
      if (byte_q == nsf_pkg::CH_COMMA && comma_r < nsf_pkg::COMMA_MAX) begin
        comma_nxt = comma_r + 7'd1;
      end
      if (byte_count_r < nsf_pkg::COUNT_MAX) begin
        byte_count_nxt = byte_count_r + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_sentence_r <= 1'b0;
      byte_count_r  <= 8'd0;
      running_xor_r <= 8'd0;
      delay_r[0]    <= 8'd0;
      delay_r[1]    <= 8'd0;
      delay_r[2]    <= 8'd0;
      delay_r[3]    <= 8'd0;
      header_r      <= '0;
      comma_r       <= 7'd0;
      prev_r        <= 8'd0;
    end else if (step) begin
      in_sentence_r <= in_sentence_nxt;
      byte_count_r  <= byte_count_nxt;
      running_xor_r <= running_xor_nxt;
      delay_r       <= delay_nxt;
      header_r      <= header_nxt;
      comma_r       <= comma_nxt;
      prev_r        <= byte_q;
    end
  end

endmodule

[rtl/core/nsf_out_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsf_out_stage
// Result register: holds one sentence report until the sink takes it.
// ----------------------------------------------------------------------------
module nsf_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             res_valid,
  input  nsf_pkg::result_t res,
  output logic             out_free,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [39:0]      out_tdata,
  output logic [1:0]       out_tuser
);

  logic             valid_r;
  logic             valid_nxt;
  nsf_pkg::result_t res_r;

  assign out_free   = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign out_tuser  = res_r.kind;
  assign out_tdata  = {6'd0, res_r.too_long, res_r.field_total, res_r.sentence_length,
                       res_r.received_sum, res_r.computed_sum, res_r.checksum_ok};

  always_comb begin
    valid_nxt = valid_r;
    if (res_valid) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      res_r <= res;
    end
  end

endmodule

[rtl/core/nmea_sentence_framer_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmea_sentence_framer_unit
// NMEA 0183 sentence framer with checksum check and header match.
// ----------------------------------------------------------------------------
// Takes one byte per clock cycle from a stream of received characters, as long
// as the output does not stall. Each byte passes an input register, the
// framing logic and a result register, so the report for the line feed that
// closes a sentence is offered from the result register. Only closing bytes
// give a report; all other bytes update internal state silently. Stalls on
// the output stop the input only once both registers are full.
module nmea_sentence_framer_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,   // byte_in
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // checksum_ok, computed_sum, received_sum, sentence_length, field_total, too_long
  output logic [39:0]                   out_tdata,
  output logic [1:0]                    out_tuser,  // sentence_kind
  input  logic                          cfg_we,
  input  logic [nsf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [nsf_pkg::HDR_W-1:0]     cfg_wdata
);

  logic [nsf_pkg::HDR_W-1:0] first_header_r;
  logic [nsf_pkg::HDR_W-1:0] second_header_r;
  logic                      out_free;
  logic                      step;
  logic [7:0]                byte_q;
  logic                      res_valid;
  nsf_pkg::result_t          res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_header_r  <= nsf_pkg::FIRST_HEADER_RST;
      second_header_r <= nsf_pkg::SECOND_HEADER_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        nsf_pkg::CFG_FIRST_HEADER:  first_header_r  <= cfg_wdata;
        nsf_pkg::CFG_SECOND_HEADER: second_header_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  nsf_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_free  (out_free),
    .step      (step),
    .byte_q    (byte_q)
  );

  nsf_framer u_framer (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (step),
    .byte_q        (byte_q),
    .first_header  (first_header_r),
    .second_header (second_header_r),
    .res_valid     (res_valid),
    .res           (res)
  );

  nsf_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res_valid),
    .res        (res),
    .out_free   (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

[rtl/core/nsf_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsf_checker
// Port-level checks of the sentence framer, bound to the top level.
// ----------------------------------------------------------------------------
module nsf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic [1:0]  out_tuser
);

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  a_ok_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> !out_tdata[33] && (out_tdata[8:1] == out_tdata[16:9]))
    else $error("checksum_ok without matching sums");

  a_too_long_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[33] |-> out_tdata[24:17] == nsf_pkg::MAX_LEN)
    else $error("overlong sentence length not limited");

  a_fields_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[32:25] != 8'd0 && out_tuser != 2'd3)
    else $error("bad field total or kind");

endmodule

bind nmea_sentence_framer_unit nsf_checker u_nsf_checker (.*);

[bench/nsf_sentence_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsf_sentence_checker
// Watches the byte stream, the register writes and the report stream of the
// NMEA sentence framer. It tracks the framing state itself, queues the report
// each closed sentence should give and compares every report field by field.
// ----------------------------------------------------------------------------
module nsf_sentence_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  input  logic                          in_tready,
  input  logic [7:0]                    in_tdata,
  input  logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic [39:0]                   out_tdata,
  input  logic [1:0]                    out_tuser,
  input  logic                          cfg_we,
  input  logic [nsf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [nsf_pkg::HDR_W-1:0]     cfg_wdata,
  output int                            fail_count,
  output int                            pending
);

  localparam int SHOWN_ERRORS = 10;

  logic [nsf_pkg::HDR_W-1:0] hdr_first;
  logic [nsf_pkg::HDR_W-1:0] hdr_second;
  logic                      open_q;
  logic [7:0]                len_q;
  logic [7:0]                xor_q;
  logic [7:0]                tail_q [4];
  logic [nsf_pkg::HDR_W-1:0] lead_q;
  logic [6:0]                comma_q;
  logic [7:0]                last_q;
  nsf_pkg::result_t          sentence_reports [$];
  int                        errors = 0;

  assign fail_count = errors;

  function automatic logic [7:0] digit_of(input logic [7:0] c);
    if (c >= nsf_pkg::CH_ZERO && c <= nsf_pkg::CH_NINE) return c - nsf_pkg::CH_ZERO;
    if (c >= nsf_pkg::CH_UPPER_A && c <= nsf_pkg::CH_UPPER_Z)
      return nsf_pkg::HEX_TEN + (c - nsf_pkg::CH_UPPER_A);
    if (c >= nsf_pkg::CH_LOWER_A && c <= nsf_pkg::CH_LOWER_Z)
      return nsf_pkg::HEX_TEN + (c - nsf_pkg::CH_LOWER_A);
    return 8'd0;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= SHOWN_ERRORS) begin
        $display("%t: %s mismatch, expected %0h, got %0h", $realtime, name, want, got);
      end
    end
  endtask

  task automatic frame_byte(input logic [7:0] b);
    nsf_pkg::result_t          r;
    logic [8:0]                total;
    logic [nsf_pkg::HDR_W-1:0] lead;
    if (b == nsf_pkg::CH_DOLLAR) begin
      open_q  = 1'b1;
      len_q   = 8'd1;
      xor_q   = 8'd0;
      tail_q  = '{8'd0, 8'd0, 8'd0, nsf_pkg::CH_DOLLAR};
      lead_q  = nsf_pkg::HDR_W'(nsf_pkg::CH_DOLLAR);
      comma_q = '0;
    end else if (b == nsf_pkg::CH_LF) begin
      if (open_q && last_q == nsf_pkg::CH_CR) begin
        total = (len_q < nsf_pkg::COUNT_MAX) ? {1'b0, len_q} + 9'd1
                                             : {1'b0, nsf_pkg::COUNT_MAX};
        lead  = lead_q;
        if (len_q < 8'(nsf_pkg::HDR_BYTES)) lead = {lead[nsf_pkg::HDR_W-9:0], b};
        r.kind = nsf_pkg::KIND_OTHER;
        if (total >= 9'(nsf_pkg::HDR_BYTES)) begin
          if (lead == hdr_first) r.kind = nsf_pkg::KIND_FIRST;
          else if (lead == hdr_second) r.kind = nsf_pkg::KIND_SECOND;
        end
        r.received_sum    = 8'((digit_of(tail_q[1]) << 4) + digit_of(tail_q[2]));
        r.computed_sum    = xor_q;
        r.too_long        = total > {1'b0, nsf_pkg::MAX_LEN};
        r.checksum_ok     = (xor_q == r.received_sum) && !r.too_long;
        r.sentence_length = r.too_long ? nsf_pkg::MAX_LEN : total[7:0];
        r.field_total     = {1'b0, comma_q} + 8'd1;
        sentence_reports.push_back(r);
        open_q = 1'b0;
      end
    end else if (open_q) begin
      if (len_q >= 8'(nsf_pkg::XOR_START)) xor_q ^= tail_q[0];
      tail_q = '{tail_q[1], tail_q[2], tail_q[3], b};
      if (len_q < 8'(nsf_pkg::HDR_BYTES)) lead_q = {lead_q[nsf_pkg::HDR_W-9:0], b};
      if (b == nsf_pkg::CH_COMMA && comma_q < nsf_pkg::COMMA_MAX) comma_q++;
      if (len_q < nsf_pkg::COUNT_MAX) len_q++;
    end
    last_q = b;
  endtask

  always @(posedge clk) begin
    nsf_pkg::result_t want;
    if (!rst_n) begin
      hdr_first  = nsf_pkg::FIRST_HEADER_RST;
      hdr_second = nsf_pkg::SECOND_HEADER_RST;
      open_q     = 1'b0;
      len_q      = 8'd0;
      xor_q      = 8'd0;
      tail_q     = '{8'd0, 8'd0, 8'd0, 8'd0};
      lead_q     = '0;
      comma_q    = '0;
      last_q     = 8'd0;
      sentence_reports.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == nsf_pkg::CFG_FIRST_HEADER) hdr_first = cfg_wdata;
        else if (cfg_index == nsf_pkg::CFG_SECOND_HEADER) hdr_second = cfg_wdata;
      end
      if (out_tvalid && out_tready) begin
        if (sentence_reports.size() == 0) begin
          errors++;
          if (errors <= SHOWN_ERRORS) begin
            $display("%t: report with none expected, tuser %0h tdata %0h",
                     $realtime, out_tuser, out_tdata);
          end
        end else begin
          want = sentence_reports.pop_front();
          check_field("sentence_kind", 8'(want.kind), 8'(out_tuser));
          check_field("checksum_ok", 8'(want.checksum_ok), 8'(out_tdata[0]));
          check_field("computed_sum", want.computed_sum, out_tdata[8:1]);
          check_field("received_sum", want.received_sum, out_tdata[16:9]);
          check_field("sentence_length", want.sentence_length, out_tdata[24:17]);
          check_field("field_total", want.field_total, out_tdata[32:25]);
          check_field("too_long", 8'(want.too_long), 8'(out_tdata[33]));
        end
      end
      if (in_tvalid && in_tready) frame_byte(in_tdata);
    end
    pending <= sentence_reports.size();
  end

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the NMEA sentence framer: directed sentences and corner cases,
// then random well-formed sentences mixed with noise and broken sentences
// under several header settings and idle patterns, with one long output stall.
// ----------------------------------------------------------------------------
module tb;

  localparam int         CYCLE_LIMIT = 200000;
  localparam int         HOLD_CYCLES = 150;
  localparam logic [7:0] CH_STAR     = 8'h2A;

  typedef enum int {SUM_UPPER, SUM_LOWER, SUM_BAD} sum_mode_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_tvalid = 1'b0;
  logic                          in_tready;
  logic [7:0]                    in_tdata = 8'd0;   // byte_in
  logic                          out_tvalid;
  logic                          out_tready = 1'b0;
  logic [39:0]                   out_tdata;         // checksum_ok, computed_sum, received_sum,
                                                    // sentence_length, field_total, too_long
  logic [1:0]                    out_tuser;         // sentence_kind
  logic                          cfg_we = 1'b0;
  logic [nsf_pkg::CFG_IDX_W-1:0] cfg_index = nsf_pkg::CFG_FIRST_HEADER;
  logic [nsf_pkg::HDR_W-1:0]     cfg_wdata = '0;

  int                        fail_count;
  int                        pending;
  int                        cycles = 0;
  int                        tx_idle = 0;
  int                        rx_idle = 0;
  logic                      hold_req = 1'b0;
  logic                      hold_ack = 1'b0;
  int                        hold_left = 0;
  logic [nsf_pkg::HDR_W-1:0] first_hdr = nsf_pkg::FIRST_HEADER_RST;
  logic [nsf_pkg::HDR_W-1:0] second_hdr = nsf_pkg::SECOND_HEADER_RST;
  logic [7:0]                frame [$];

  nmea_sentence_framer_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  nsf_sentence_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // hold off the report stream for a long stretch on request
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack   <= hold_req;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle);
    end
  end

  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
    if (8'(n) < nsf_pkg::HEX_TEN) return nsf_pkg::CH_ZERO + 8'(n);
    return (lower ? nsf_pkg::CH_LOWER_A : nsf_pkg::CH_UPPER_A) + 8'(n) - nsf_pkg::HEX_TEN;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    logic ok;
    while ($urandom_range(99) < tx_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do begin
      @(negedge clk);
      ok = in_tready;
      @(posedge clk);
    end while (!ok);
  endtask

  task automatic send_frame();
    foreach (frame[i]) send_byte(frame[i]);
  endtask

  task automatic frame_text(input string s, input bit close);
    frame.delete();
    for (int i = 0; i < s.len(); i++) frame.push_back(s[i]);
    if (close) begin
      frame.push_back(nsf_pkg::CH_CR);
      frame.push_back(nsf_pkg::CH_LF);
    end
  endtask

  task automatic make_sentence(input logic [nsf_pkg::HDR_W-1:0] hdr, input int body_len,
                               input int comma_pct, input sum_mode_t mode);
    logic [7:0] acc;
    logic [7:0] c;
    acc = 8'd0;
    frame.delete();
    frame.push_back(nsf_pkg::CH_DOLLAR);
    for (int k = 4; k >= 0; k--) begin
      c = hdr[8*k +: 8];
      frame.push_back(c);
      acc ^= c;
    end
    for (int k = 0; k < body_len; k++) begin
      c = ($urandom_range(99) < comma_pct) ? nsf_pkg::CH_COMMA : 8'($urandom_range(126, 32));
      if (c == nsf_pkg::CH_DOLLAR) c = nsf_pkg::CH_UPPER_A;
      frame.push_back(c);
      acc ^= c;
    end
    frame.push_back(CH_STAR);
    if (mode == SUM_BAD) begin
      repeat (2) begin
        c = 8'($urandom_range(255));
        if (c == nsf_pkg::CH_DOLLAR || c == nsf_pkg::CH_LF) c = nsf_pkg::CH_UPPER_Z;
        frame.push_back(c);
      end
    end else begin
      frame.push_back(hex_char(acc[7:4], mode == SUM_LOWER));
      frame.push_back(hex_char(acc[3:0], mode == SUM_LOWER));
    end
    frame.push_back(nsf_pkg::CH_CR);
    frame.push_back(nsf_pkg::CH_LF);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_headers(input logic [nsf_pkg::HDR_W-1:0] a,
                             input logic [nsf_pkg::HDR_W-1:0] b);
    cfg_we    <= 1'b1;
    cfg_index <= nsf_pkg::CFG_FIRST_HEADER;
    cfg_wdata <= a;
    @(posedge clk);
    cfg_index <= nsf_pkg::CFG_SECOND_HEADER;
    cfg_wdata <= b;
    @(posedge clk);
    cfg_we     <= 1'b0;
    first_hdr  = a;
    second_hdr = b;
  endtask

  task automatic run_random(input int quota);
    int                        sent;
    int                        r;
    int                        m;
    logic [nsf_pkg::HDR_W-1:0] hdr;
    sum_mode_t                 mode;
    sent = 0;
    while (sent < quota) begin
      r = $urandom_range(99);
      case ($urandom_range(2))
        0:       hdr = first_hdr;
        1:       hdr = second_hdr;
        default: begin
          hdr = nsf_pkg::HDR_W'(nsf_pkg::CH_DOLLAR);
          repeat (5) hdr = {hdr[nsf_pkg::HDR_W-9:0],
                            8'($urandom_range(nsf_pkg::CH_UPPER_Z, nsf_pkg::CH_UPPER_A))};
        end
      endcase
      m = $urandom_range(9);
      mode = (m < 8) ? SUM_UPPER : (m == 8) ? SUM_LOWER : SUM_BAD;
      make_sentence(hdr, ($urandom_range(99) < 3) ? $urandom_range(300, 120)
                                                  : $urandom_range(30, 0),
                    $urandom_range(40, 0), mode);
      if (r < 75) begin
      end else if (r < 80) begin
        frame.delete();
        repeat ($urandom_range(6, 1)) frame.push_back(8'($urandom_range(255)));
      end else if (r < 85) begin
        frame.insert($urandom_range(frame.size() - 2, 1), nsf_pkg::CH_LF);
      end else if (r < 90) begin
        frame = frame[0:$urandom_range(frame.size() - 2, 0)];
      end else if (r < 95) begin
        frame[frame.size() - 1] = 8'($urandom_range(255));
      end else begin
        frame_text("$", 1'b0);
        repeat ($urandom_range(5, 0))
          frame.push_back(8'($urandom_range(nsf_pkg::CH_UPPER_Z, nsf_pkg::CH_UPPER_A)));
        frame.push_back(nsf_pkg::CH_CR);
        frame.push_back(nsf_pkg::CH_LF);
      end
      if (r < 75 || r >= 80) sent += frame.size();
      send_frame();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n   <= 1'b1;
    tx_idle = 24;
    rx_idle = 48;

    make_sentence(first_hdr, 20, 20, SUM_UPPER);
    send_frame();
    make_sentence(second_hdr, 15, 30, SUM_LOWER);
    send_frame();
    make_sentence(48'("$GPGSV"), 10, 10, SUM_BAD);
    send_frame();
    frame = {8'h00, 8'hFF, 8'h55, 8'hAA, nsf_pkg::CH_CR, nsf_pkg::CH_LF, CH_STAR,
             nsf_pkg::CH_LF};
    send_frame();
    make_sentence(first_hdr, 12, 20, SUM_UPPER);
    frame.insert(8, nsf_pkg::CH_LF);
    send_frame();
    make_sentence(second_hdr, 12, 20, SUM_UPPER);
    frame = frame[0:9];
    send_frame();
    make_sentence(second_hdr, 8, 20, SUM_UPPER);
    send_frame();
    frame_text("$", 1'b1);
    send_frame();
    frame_text("$A", 1'b1);
    send_frame();
    frame_text("$GPG", 1'b1);
    send_frame();
    frame_text("$GPGG", 1'b1);
    send_frame();
    frame_text("$GPGGA", 1'b1);
    send_frame();
    make_sentence(first_hdr, 117, 20, SUM_UPPER);
    send_frame();
    make_sentence(first_hdr, 118, 20, SUM_UPPER);
    send_frame();
    make_sentence(first_hdr, 200, 10, SUM_UPPER);
    send_frame();
    make_sentence(second_hdr, 300, 100, SUM_UPPER);
    send_frame();
    make_sentence(first_hdr, 6, 0, SUM_UPPER);
    frame[frame.size() - 4] = 8'h67;
    frame[frame.size() - 3] = 8'h23;
    send_frame();
    frame_text("$GPRMC,1", 1'b0);
    frame.push_back(nsf_pkg::CH_CR);
    frame.push_back(nsf_pkg::CH_CR);
    frame.push_back(nsf_pkg::CH_LF);
    send_frame();

    tx_idle = 0;
    hold_req <= ~hold_req;
    repeat (30) begin
      make_sentence(first_hdr, 0, 0, SUM_UPPER);
      send_frame();
    end

    tx_idle = 24;
    drain();
    run_random(150);

    drain();
    set_headers('0, '1);
    run_random(50);

    drain();
    set_headers(48'("$GPGSV"), {"$ABC", nsf_pkg::CH_CR, nsf_pkg::CH_LF});
    tx_idle = 48;
    rx_idle = 24;
    frame_text("$ABC", 1'b1);
    send_frame();
    make_sentence(first_hdr, 10, 20, SUM_UPPER);
    send_frame();
    run_random(125);

    drain();
    set_headers(48'("$GNGLL"), 48'("$GNGLL"));
    tx_idle = 0;
    rx_idle = 0;
    make_sentence(first_hdr, 10, 20, SUM_UPPER);
    send_frame();
    run_random(125);

    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
